@@ hw/rtl/fdtd_pkg.sv @@
package fdtd_pkg;

  // q8.24 fixed point
  localparam int FRAC_BITS = 24;

  // item codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VOLT_COEFF   = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURR_COEFF   = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_SCALE  = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_GAIN   = 8'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_COND     = 8'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HARD_SOURCE  = 8'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RISE_STEPS   = 8'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLAT_STEPS   = 8'd7;

  // pulse divider sizes: quotient = num * 2^24 / rise, num <= 2 * rise
  localparam int PULSE_NUM_BITS = 17;
  localparam int PULSE_DEN_BITS = 16;
  localparam int PULSE_Q_BITS   = 26;

  localparam int STEP_BITS = 20;

  // divider handshake
  typedef struct packed {
    logic start;
    logic [PULSE_NUM_BITS-1:0] num;
    logic [PULSE_DEN_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [PULSE_Q_BITS-1:0] quo;
  } div_rsp_t;

  typedef enum logic [25:0] {
    ST_CLEAR   = 26'h0000001,
    ST_IDLE    = 26'h0000002,
    ST_RD_WAIT = 26'h0000004,
    ST_PULSE   = 26'h0000008,
    ST_PDIV    = 26'h0000010,
    ST_A_INIT  = 26'h0000020,
    ST_A_INIT2 = 26'h0000040,
    ST_A_RD    = 26'h0000080,
    ST_A_SUB   = 26'h0000100,
    ST_A_MUL   = 26'h0000200,
    ST_S_BEGIN = 26'h0000400,
    ST_S_M1    = 26'h0000800,
    ST_S_M2    = 26'h0001000,
    ST_S_M3S   = 26'h0002000,
    ST_S_M3    = 26'h0004000,
    ST_L_RD    = 26'h0008000,
    ST_L_M1S   = 26'h0010000,
    ST_L_M1    = 26'h0020000,
    ST_L_M2S   = 26'h0040000,
    ST_L_M2    = 26'h0080000,
    ST_C_INIT  = 26'h0100000,
    ST_C_INIT2 = 26'h0200000,
    ST_C_RD    = 26'h0400000,
    ST_C_SUB   = 26'h0800000,
    ST_C_MUL   = 26'h1000000,
    ST_EMIT    = 26'h2000000
  } seq_state_t;

endpackage

@@ hw/rtl/fdtd_in_if.sv @@
interface fdtd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] node_index;

  modport source (output valid, req_type, node_index, input ready);
  modport sink (input valid, req_type, node_index, output ready);
endinterface

@@ hw/rtl/fdtd_out_if.sv @@
interface fdtd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] node_volts;
  logic signed [31:0] segment_amps;
  logic signed [31:0] source_volts;
  logic        [19:0] step_number;

  modport source (output valid, node_volts, segment_amps, source_volts, step_number,
                  input ready);
  modport sink (input valid, node_volts, segment_amps, source_volts, step_number,
                output ready);
endinterface

@@ hw/rtl/fdtd_cfg_if.sv @@
interface fdtd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ hw/rtl/fdtd_mul.sv @@
module fdtd_mul
  import fdtd_pkg::*;
#(
  parameter int OPW = 32,
  parameter int W   = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [OPW-1:0] a,
  input  logic [OPW-1:0] b,
  output logic           done,
  output logic [W-1:0]   p
);

  localparam int PW = 2 * OPW;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] LIM_POS = ((PW + 1)'(1) << (W - 1)) - (PW + 1)'(1);
  localparam logic [PW:0] LIM_NEG = (PW + 1)'(1) << (W - 1);

  logic [PW-1:0]  ua_r, ua_nxt;
  logic [OPW-1:0] ub_r, ub_nxt;
  logic [PW-1:0]  acc_r, acc_nxt;
  logic           neg_r, neg_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;

  logic [OPW-1:0] ma, mb;
  logic [PW:0]    rnd, mag_res;

  assign ma = a[OPW-1] ? (~a + OPW'(1)) : a;
  assign mb = b[OPW-1] ? (~b + OPW'(1)) : b;

  // one 16-bit digit of the multiplier per cycle
  always_comb begin
    ua_nxt   = ua_r;
    ub_nxt   = ub_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      ua_nxt   = PW'(ma);
      ub_nxt   = mb;
      acc_nxt  = '0;
      neg_nxt  = a[OPW-1] ^ b[OPW-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + PW'(ua_r * PW'(ub_r[15:0]));
      ua_nxt  = ua_r << 16;
      ub_nxt  = ub_r >> 16;
      if ((ub_r >> 16) == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    ua_r  <= ua_nxt;
    ub_r  <= ub_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
  end

  // round half away from zero on the magnitude, then clamp
  always_comb begin
    rnd     = ({1'b0, acc_r} + HALF) >> FRAC_BITS;
    mag_res = rnd;
    if (neg_r && rnd > LIM_NEG) mag_res = LIM_NEG;
    if (!neg_r && rnd > LIM_POS) mag_res = LIM_POS;
    p = neg_r ? W'(~mag_res + (PW + 1)'(1)) : W'(mag_res);
  end

  assign done = done_r;

endmodule

@@ hw/rtl/fdtd_div.sv @@
module fdtd_div
  import fdtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(PULSE_Q_BITS);

  logic [PULSE_DEN_BITS:0]   rem_r, rem_nxt;
  logic [PULSE_Q_BITS-1:0]   bits_r, bits_nxt;
  logic [PULSE_Q_BITS-1:0]   quo_r, quo_nxt;
  logic [PULSE_DEN_BITS-1:0] den_r, den_nxt;
  logic [CNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [PULSE_DEN_BITS:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[PULSE_DEN_BITS-1:0], bits_r[PULSE_Q_BITS-1]};
    if (req.start) begin
      // top part of num * 2^24 is below the divisor
      rem_nxt  = (PULSE_DEN_BITS + 1)'(req.num >> 2);
      bits_nxt = {req.num[1:0], {(PULSE_Q_BITS - 2){1'b0}}};
      den_nxt  = req.den;
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bits_nxt = bits_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[PULSE_Q_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[PULSE_Q_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(PULSE_Q_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ hw/rtl/fdtd_line_step.sv @@
// One-dimensional transmission line solver, leapfrog scheme in signed Q8.24 with
// saturation. The line holds CELLS+1 node voltages and CELLS segment currents in
// two on-chip memories. A tick item advances one time step (interior voltages,
// source node, load node, then all currents) and returns the load node voltage,
// the last segment current, the pulse value and the step count; a read item
// returns the voltage and current at node_index and changes nothing. All
// products go through one shared multiplier that retires a 16-bit digit per
// cycle. A tick makes two passes over the line, each node needing a memory
// read, a subtract, a multiply and a write-back, and it also waits for the
// pulse division when the pulse is on a ramp. After reset the memories are
// zeroed, and no item is taken until that is done; configuration writes are
// always taken.
module fdtd_line_step
  import fdtd_pkg::*;
#(
  parameter int CELLS     = 128,
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  fdtd_in_if.sink    in_ch,
  fdtd_out_if.source out_ch,
  fdtd_cfg_if.sink   cfg_ch
);

  localparam int W   = WORD_BITS;
  localparam int OPW = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam int VA  = $clog2(CELLS + 1);
  localparam int IA  = $clog2(CELLS);
  localparam logic [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};
  localparam logic [63:0]  WMAX64 = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [PULSE_Q_BITS-1:0] PEAK_Q = PULSE_Q_BITS'(1) << (FRAC_BITS + 1);

  // saturating add and subtract on line words
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} - {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  // configuration registers
  logic [31:0] volt_coeff_r, curr_coeff_r, bound_scale_r, bound_gain_r, src_cond_r;
  logic        hard_source_r;
  logic [15:0] rise_steps_r, flat_steps_r;

  // sequencer and datapath registers
  seq_state_t          state_r, state_nxt;
  logic [VA-1:0]       k_r, k_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [W-1:0]        last_src_r, last_src_nxt;
  logic [W-1:0]        vs_r, vs_nxt;
  logic [W-1:0]        prev_r, prev_nxt;     // previous current or voltage of the pass
  logic [W-1:0]        i0_r, i0_nxt;
  logic [W-1:0]        v0_r, v0_nxt;
  logic [W-1:0]        vold_r, vold_nxt;
  logic [W-1:0]        iold_r, iold_nxt;
  logic [W-1:0]        acc_r, acc_nxt;
  logic                rd_v_ok_r, rd_v_ok_nxt;
  logic                rd_i_ok_r, rd_i_ok_nxt;
  logic [W-1:0]        res_v_r, res_v_nxt;
  logic [W-1:0]        res_i_r, res_i_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_v_r, out_v_nxt;
  logic [31:0]          out_i_r, out_i_nxt;
  logic [31:0]          out_s_r, out_s_nxt;
  logic [STEP_BITS-1:0] out_n_r, out_n_nxt;

  // line memories
  logic [W-1:0]  vmem [CELLS+1];
  logic [W-1:0]  imem [CELLS];
  logic          v_we, v_re, i_we, i_re;
  logic [VA-1:0] v_wa, v_ra;
  logic [IA-1:0] i_wa, i_ra;
  logic [W-1:0]  v_wd, i_wd;
  logic [W-1:0]  vrd_r, ird_r;

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_wa] <= v_wd;
    if (v_re) vrd_r <= vmem[v_ra];
  end

  always_ff @(posedge clk) begin
    if (i_we) imem[i_wa] <= i_wd;
    if (i_re) ird_r <= imem[i_ra];
  end

  // shared multiplier
  logic           mul_start, mul_done;
  logic [OPW-1:0] mul_a, mul_b;
  logic [W-1:0]   mul_p;

  fdtd_mul #(.OPW(OPW), .W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // pulse ramp divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  fdtd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // pulse timing in half-steps
  logic [STEP_BITS:0]   half_t;
  logic [STEP_BITS:0]   rise_h, top_end, fall_end;
  logic [W-1:0]         div_sat;

  assign half_t   = {step_r, 1'b0} - (STEP_BITS + 1)'(1);
  assign rise_h   = (STEP_BITS + 1)'({rise_steps_r, 1'b0});
  assign top_end  = rise_h + (STEP_BITS + 1)'({flat_steps_r, 1'b0});
  assign fall_end = top_end + rise_h;
  assign div_sat  = (64'(div_rsp.quo) > WMAX64) ? WMAX : W'(div_rsp.quo);

  logic in_acc, cfg_acc, out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    step_nxt     = step_r;
    last_src_nxt = last_src_r;
    vs_nxt       = vs_r;
    prev_nxt     = prev_r;
    i0_nxt       = i0_r;
    v0_nxt       = v0_r;
    vold_nxt     = vold_r;
    iold_nxt     = iold_r;
    acc_nxt      = acc_r;
    rd_v_ok_nxt  = rd_v_ok_r;
    rd_i_ok_nxt  = rd_i_ok_r;
    res_v_nxt    = res_v_r;
    res_i_nxt    = res_i_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_v_nxt    = out_v_r;
    out_i_nxt    = out_i_r;
    out_s_nxt    = out_s_r;
    out_n_nxt    = out_n_r;
    v_we = 1'b0; v_re = 1'b0; i_we = 1'b0; i_re = 1'b0;
    v_wa = k_r;  v_ra = k_r;  i_wa = IA'(k_r); i_ra = IA'(k_r);
    v_wd = '0;   i_wd = '0;
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_req = '0;

    case (state_r)
      // zero both memories after reset
      ST_CLEAR: begin
        v_we = 1'b1;
        i_we = (32'(k_r) < CELLS);
        if (32'(k_r) == CELLS) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + VA'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == REQ_READ) begin
            v_re = 1'b1;
            i_re = 1'b1;
            v_ra = VA'(in_ch.node_index);
            i_ra = IA'(in_ch.node_index);
            rd_v_ok_nxt = (32'(in_ch.node_index) <= CELLS);
            rd_i_ok_nxt = (32'(in_ch.node_index) < CELLS);
            state_nxt = ST_RD_WAIT;
          end else begin
            state_nxt = ST_PULSE;
          end
        end
      end
      ST_RD_WAIT: begin
        res_v_nxt = rd_v_ok_r ? vrd_r : '0;
        res_i_nxt = rd_i_ok_r ? ird_r : '0;
        state_nxt = ST_EMIT;
      end
      // trapezoid pulse at half-step 2n-1
      ST_PULSE: begin
        state_nxt = ST_A_INIT;
        if (step_r == '0) begin
          vs_nxt = '0;
        end else if (half_t <= rise_h) begin
          div_req.start = 1'b1;
          div_req.num   = PULSE_NUM_BITS'(half_t);
          div_req.den   = rise_steps_r;
          state_nxt     = ST_PDIV;
        end else if (half_t <= top_end) begin
          vs_nxt = (64'(PEAK_Q) > WMAX64) ? WMAX : W'(PEAK_Q);
        end else if (half_t <= fall_end) begin
          div_req.start = 1'b1;
          div_req.num   = PULSE_NUM_BITS'(fall_end - half_t);
          div_req.den   = rise_steps_r;
          state_nxt     = ST_PDIV;
        end else begin
          vs_nxt = '0;
        end
      end
      ST_PDIV: begin
        if (div_rsp.done) begin
          vs_nxt    = div_sat;
          state_nxt = ST_A_INIT;
        end
      end
      // interior node pass
      ST_A_INIT: begin
        v_re = 1'b1;
        i_re = 1'b1;
        v_ra = '0;
        i_ra = '0;
        state_nxt = ST_A_INIT2;
      end
      ST_A_INIT2: begin
        v0_nxt    = vrd_r;
        i0_nxt    = ird_r;
        prev_nxt  = ird_r;
        k_nxt     = VA'(1);
        state_nxt = ST_A_RD;
      end
      ST_A_RD: begin
        v_re = 1'b1;
        i_re = 1'b1;
        state_nxt = ST_A_SUB;
      end
      ST_A_SUB: begin
        vold_nxt  = vrd_r;
        iold_nxt  = ird_r;
        mul_start = 1'b1;
        mul_a     = OPW'($signed(volt_coeff_r));
        mul_b     = OPW'($signed(sat_sub(ird_r, prev_r)));
        state_nxt = ST_A_MUL;
      end
      ST_A_MUL: begin
        if (mul_done) begin
          v_we     = 1'b1;
          v_wd     = sat_sub(vold_r, mul_p);
          prev_nxt = iold_r;
          if (32'(k_r) == CELLS - 1) begin
            state_nxt = ST_S_BEGIN;
          end else begin
            k_nxt     = k_r + VA'(1);
            state_nxt = ST_A_RD;
          end
        end
      end
      // source node
      ST_S_BEGIN: begin
        if (hard_source_r) begin
          v_we      = 1'b1;
          v_wa      = '0;
          v_wd      = vs_r;
          state_nxt = ST_L_RD;
        end else begin
          mul_start = 1'b1;
          mul_a     = OPW'($signed(bound_gain_r));
          mul_b     = OPW'($signed(v0_r));
          state_nxt = ST_S_M1;
        end
      end
      ST_S_M1: begin
        if (mul_done) begin
          acc_nxt   = sat_sub(mul_p, i0_r);
          mul_start = 1'b1;
          mul_a     = OPW'($signed(vs_r));
          mul_b     = OPW'($signed(src_cond_r));
          state_nxt = ST_S_M2;
        end
      end
      ST_S_M2: begin
        if (mul_done) begin
          acc_nxt   = sat_add(acc_r, mul_p);
          state_nxt = ST_S_M3S;
        end
      end
      ST_S_M3S: begin
        mul_start = 1'b1;
        mul_a     = OPW'($signed(bound_scale_r));
        mul_b     = OPW'($signed(acc_r));
        state_nxt = ST_S_M3;
      end
      ST_S_M3: begin
        if (mul_done) begin
          v_we      = 1'b1;
          v_wa      = '0;
          v_wd      = mul_p;
          state_nxt = ST_L_RD;
        end
      end
      // load node, prev_r holds the last segment current
      ST_L_RD: begin
        v_re      = 1'b1;
        v_ra      = VA'(CELLS);
        state_nxt = ST_L_M1S;
      end
      ST_L_M1S: begin
        mul_start = 1'b1;
        mul_a     = OPW'($signed(bound_gain_r));
        mul_b     = OPW'($signed(vrd_r));
        state_nxt = ST_L_M1;
      end
      ST_L_M1: begin
        if (mul_done) begin
          acc_nxt   = sat_add(mul_p, prev_r);
          state_nxt = ST_L_M2S;
        end
      end
      ST_L_M2S: begin
        mul_start = 1'b1;
        mul_a     = OPW'($signed(bound_scale_r));
        mul_b     = OPW'($signed(acc_r));
        state_nxt = ST_L_M2;
      end
      ST_L_M2: begin
        if (mul_done) begin
          v_we      = 1'b1;
          v_wa      = VA'(CELLS);
          v_wd      = mul_p;
          state_nxt = ST_C_INIT;
        end
      end
      // current pass over the new voltages
      ST_C_INIT: begin
        v_re      = 1'b1;
        v_ra      = '0;
        state_nxt = ST_C_INIT2;
      end
      ST_C_INIT2: begin
        prev_nxt  = vrd_r;
        k_nxt     = '0;
        state_nxt = ST_C_RD;
      end
      ST_C_RD: begin
        v_re      = 1'b1;
        i_re      = 1'b1;
        v_ra      = k_r + VA'(1);
        state_nxt = ST_C_SUB;
      end
      ST_C_SUB: begin
        vold_nxt  = vrd_r;
        iold_nxt  = ird_r;
        mul_start = 1'b1;
        mul_a     = OPW'($signed(curr_coeff_r));
        mul_b     = OPW'($signed(sat_sub(vrd_r, prev_r)));
        state_nxt = ST_C_MUL;
      end
      ST_C_MUL: begin
        if (mul_done) begin
          i_we     = 1'b1;
          i_wd     = sat_sub(iold_r, mul_p);
          prev_nxt = vold_r;
          if (32'(k_r) == CELLS - 1) begin
            res_v_nxt    = vold_r;
            res_i_nxt    = sat_sub(iold_r, mul_p);
            last_src_nxt = vs_r;
            if (step_r != '1) step_nxt = step_r + STEP_BITS'(1);
            state_nxt = ST_EMIT;
          end else begin
            k_nxt     = k_r + VA'(1);
            state_nxt = ST_C_RD;
          end
        end
      end
      // hand the item to the result register
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_v_nxt     = 32'($signed(res_v_r));
          out_i_nxt     = 32'($signed(res_i_r));
          out_s_nxt     = 32'($signed(last_src_r));
          out_n_nxt     = step_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        k_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      k_r           <= '0;
      step_r        <= '0;
      last_src_r    <= '0;
      out_valid_r   <= 1'b0;
      volt_coeff_r  <= 32'd838860800;
      curr_coeff_r  <= 32'd335544;
      bound_scale_r <= 32'd1676045;
      bound_gain_r  <= 32'd167604388;
      src_cond_r    <= 32'd335544;
      hard_source_r <= 1'b0;
      rise_steps_r  <= 16'd8;
      flat_steps_r  <= 16'd20;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      last_src_r  <= last_src_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) begin
        case (cfg_ch.reg_index)
          CFG_VOLT_COEFF:  volt_coeff_r  <= cfg_ch.wdata;
          CFG_CURR_COEFF:  curr_coeff_r  <= cfg_ch.wdata;
          CFG_BOUND_SCALE: bound_scale_r <= cfg_ch.wdata;
          CFG_BOUND_GAIN:  bound_gain_r  <= cfg_ch.wdata;
          CFG_SRC_COND:    src_cond_r    <= cfg_ch.wdata;
          CFG_HARD_SOURCE: hard_source_r <= cfg_ch.wdata[0];
          CFG_RISE_STEPS:  rise_steps_r  <= cfg_ch.wdata[15:0];
          CFG_FLAT_STEPS:  flat_steps_r  <= cfg_ch.wdata[15:0];
          default: ;
        endcase
      end
    end
    vs_r      <= vs_nxt;
    prev_r    <= prev_nxt;
    i0_r      <= i0_nxt;
    v0_r      <= v0_nxt;
    vold_r    <= vold_nxt;
    iold_r    <= iold_nxt;
    acc_r     <= acc_nxt;
    rd_v_ok_r <= rd_v_ok_nxt;
    rd_i_ok_r <= rd_i_ok_nxt;
    res_v_r   <= res_v_nxt;
    res_i_r   <= res_i_nxt;
    out_v_r   <= out_v_nxt;
    out_i_r   <= out_i_nxt;
    out_s_r   <= out_s_nxt;
    out_n_r   <= out_n_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.node_volts   = out_v_r;
  assign out_ch.segment_amps = out_i_r;
  assign out_ch.source_volts = out_s_r;
  assign out_ch.step_number  = out_n_r;

endmodule
